// ===== rtl/cdad_pkg.sv =====
// Shared types, constants and month-length table for the date adder.
`timescale 1ns / 1ps

package cdad_pkg;

  localparam int unsigned YEAR_LIMIT  = 9999;
  localparam int unsigned OFFSET_BITS = 16;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_IN_W = 14;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned YEAR_W =
    ($clog2(YEAR_LIMIT + 1) > YEAR_IN_W) ? $clog2(YEAR_LIMIT + 1) : YEAR_IN_W;

  localparam int unsigned LEAP_CYCLE = 400;
  localparam int unsigned CENTURY    = 100;
  localparam int unsigned REM_W      = $clog2(LEAP_CYCLE);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [REM_W-1:0]   rem400;
  } date_t;

  typedef struct packed {
    date_t            date;
    logic             range_err;
    logic [DAY_W-1:0] cur_len;
  } step_res_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    n = DAY_W'(30);
      MONTH_FEB:                                  n = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/calendar_date_add_days_unit.sv =====
// Top level: Gregorian date plus signed day offset, stepped one day per cycle.
//
//   channel   ports                                        handshake
//   command   start_day_i start_month_i start_year_i       start && !busy
//             day_offset_i
//   result    result_day_o result_month_o result_year_o    result_valid_o, one cycle
//             status_o
//
// After acceptance the year is reduced modulo 400 in ST_MOD, the date is checked in ST_CHECK,
// then the step unit moves one day per cycle for |day_offset| days in ST_STEP. The strobe
// is registered from the finishing state; an invalid date or a zero offset gives it straight
// from ST_CHECK, a range error ends the walk early.
// busy drops in the strobe cycle, so a new transaction can be taken then.
// Reset clears the sequencer and the strobe. The receiver cannot stall.
`timescale 1ns / 1ps

module calendar_date_add_days_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [cdad_pkg::DAY_W-1:0]               start_day_i,
  input  logic [cdad_pkg::MONTH_W-1:0]             start_month_i,
  input  logic [cdad_pkg::YEAR_IN_W-1:0]           start_year_i,
  input  logic signed [cdad_pkg::OFFSET_BITS-1:0]  day_offset_i,
  output logic                                     result_valid_o,
  output logic [cdad_pkg::DAY_W-1:0]               result_day_o,
  output logic [cdad_pkg::MONTH_W-1:0]             result_month_o,
  output logic [cdad_pkg::YEAR_IN_W-1:0]           result_year_o,
  output logic [cdad_pkg::STATUS_W-1:0]            status_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOD   = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_STEP  = 2'd3;

  logic [1:0]                         state_q, state_d;
  cdad_pkg::date_t                    cur_q, cur_d;
  logic [cdad_pkg::OFFSET_BITS-1:0]   cnt_q, cnt_d;
  logic                               back_q, back_d;
  logic [cdad_pkg::DAY_W-1:0]         sday_q;
  logic [cdad_pkg::MONTH_W-1:0]       smonth_q;
  logic [cdad_pkg::YEAR_IN_W-1:0]     syear_q;
  logic                               valid_q;
  logic [cdad_pkg::DAY_W-1:0]         rday_q;
  logic [cdad_pkg::MONTH_W-1:0]       rmonth_q;
  logic [cdad_pkg::YEAR_IN_W-1:0]     ryear_q;
  cdad_pkg::status_e                  rstatus_q;

  logic                               accept;
  logic                               mod_done;
  logic [cdad_pkg::REM_W-1:0]         mod_rem;
  cdad_pkg::step_res_t                step;
  logic                               invalid;
  logic                               fin;
  cdad_pkg::status_e                  fin_st;
  cdad_pkg::date_t                    fin_date;
  logic [cdad_pkg::OFFSET_BITS-1:0]   offs_u;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign offs_u = $unsigned(day_offset_i);

  cdad_yrmod u_yrmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .year_i (cdad_pkg::YEAR_W'(start_year_i)),
    .rem_o  (mod_rem),
    .done_o (mod_done)
  );

  cdad_step u_step (
    .date_i (cur_q),
    .back_i (back_q),
    .res_o  (step)
  );

  always_comb begin
    invalid = (cur_q.year == '0) ||
              (cur_q.year > cdad_pkg::YEAR_W'(cdad_pkg::YEAR_LIMIT)) ||
              (cur_q.month == '0) || (cur_q.month > cdad_pkg::MONTH_DEC) ||
              (cur_q.day == '0) || (cur_q.day > step.cur_len);
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    back_d   = back_q;
    fin      = 1'b0;
    fin_st   = cdad_pkg::STATUS_OK;
    fin_date = cur_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cur_d.day    = start_day_i;
          cur_d.month  = start_month_i;
          cur_d.year   = cdad_pkg::YEAR_W'(start_year_i);
          cur_d.rem400 = '0;
          back_d       = day_offset_i[cdad_pkg::OFFSET_BITS-1];
          cnt_d        = back_d ? (cdad_pkg::OFFSET_BITS'(0) - offs_u) : offs_u;
          state_d      = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          cur_d.rem400 = mod_rem;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (invalid) begin
          fin    = 1'b1;
          fin_st = cdad_pkg::STATUS_BAD_DATE;
        end else if (cnt_q == '0) begin
          fin = 1'b1;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step.range_err) begin
          fin    = 1'b1;
          fin_st = cdad_pkg::STATUS_RANGE;
        end else begin
          cur_d    = step.date;
          cnt_d    = cnt_q - 1'b1;
          fin_date = step.date;
          if (cnt_q == cdad_pkg::OFFSET_BITS'(1)) begin
            fin = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (fin) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    cnt_q  <= cnt_d;
    back_q <= back_d;
    if (accept) begin
      sday_q   <= start_day_i;
      smonth_q <= start_month_i;
      syear_q  <= start_year_i;
    end
    if (fin) begin
      rstatus_q <= fin_st;
      if (fin_st != cdad_pkg::STATUS_OK) begin
        rday_q   <= sday_q;
        rmonth_q <= smonth_q;
        ryear_q  <= syear_q;
      end else begin
        rday_q   <= fin_date.day;
        rmonth_q <= fin_date.month;
        ryear_q  <= fin_date.year[cdad_pkg::YEAR_IN_W-1:0];
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_day_o   = rday_q;
  assign result_month_o = rmonth_q;
  assign result_year_o  = ryear_q;
  assign status_o       = rstatus_q;

`ifndef NO_ASSERTIONS
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted transaction did not raise busy");

  a_ok_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == cdad_pkg::STATUS_OK)) |->
    ((result_month_o != '0) && (result_month_o <= cdad_pkg::MONTH_DEC) &&
     (result_day_o != '0)))
    else $error("ok result with out-of-range date");
`endif

endmodule

// ===== rtl/cdad_yrmod.sv =====
// Year modulo 400 by reciprocal multiplication, registered on load.
`timescale 1ns / 1ps

module cdad_yrmod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [cdad_pkg::YEAR_W-1:0]    year_i,
  output logic [cdad_pkg::REM_W-1:0]     rem_o,
  output logic                           done_o
);

  // 400 = 16 * 25: drop four bits, then divide by 25 as * 5243 >> 17
  localparam int unsigned QX_W      = cdad_pkg::YEAR_W - 4;
  localparam int unsigned RCP_SHIFT = 17;
  localparam int unsigned PROD_W    = QX_W + 13;
  localparam logic [12:0] RCP_25    = 13'd5243;

  logic [QX_W-1:0]               year_q16;
  logic [PROD_W-1:0]             prod;
  logic [PROD_W-RCP_SHIFT-1:0]   quot;
  logic [cdad_pkg::YEAR_W-1:0]   rem_full;
  logic [cdad_pkg::REM_W-1:0]    rem_q, rem_d;
  logic                          done_q;

  always_comb begin
    year_q16 = year_i[cdad_pkg::YEAR_W-1:4];
    prod     = PROD_W'(year_q16) * PROD_W'(RCP_25);
    quot     = prod[PROD_W-1:RCP_SHIFT];
    rem_full = year_i - cdad_pkg::YEAR_W'(quot * cdad_pkg::LEAP_CYCLE);
    rem_d    = rem_full[cdad_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= rem_d;
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== rtl/cdad_step.sv =====
// One-day step unit: next date forward or back, month length, range error.
`timescale 1ns / 1ps

module cdad_step (
  input  cdad_pkg::date_t     date_i,
  input  logic                back_i,
  output cdad_pkg::step_res_t res_o
);

  logic                          leap;
  logic [cdad_pkg::DAY_W-1:0]    cur_len;
  logic [cdad_pkg::DAY_W-1:0]    prev_len;
  logic [cdad_pkg::MONTH_W-1:0]  prev_month;
  logic [cdad_pkg::REM_W-1:0]    r;

  always_comb begin
    r    = date_i.rem400;
    leap = (date_i.year[1:0] == 2'b00) &&
           (r != cdad_pkg::REM_W'(cdad_pkg::CENTURY)) &&
           (r != cdad_pkg::REM_W'(2 * cdad_pkg::CENTURY)) &&
           (r != cdad_pkg::REM_W'(3 * cdad_pkg::CENTURY));
    prev_month = date_i.month - 1'b1;
    cur_len    = cdad_pkg::month_len(date_i.month, leap);
    prev_len   = cdad_pkg::month_len(prev_month, leap);

    res_o.date      = date_i;
    res_o.range_err = 1'b0;
    res_o.cur_len   = cur_len;

    if (!back_i) begin
      if (date_i.day < cur_len) begin
        res_o.date.day = date_i.day + 1'b1;
      end else if (date_i.month == cdad_pkg::MONTH_DEC) begin
        if (date_i.year >= cdad_pkg::YEAR_W'(cdad_pkg::YEAR_LIMIT)) begin
          res_o.range_err = 1'b1;
        end else begin
          res_o.date.year   = date_i.year + 1'b1;
          res_o.date.month  = cdad_pkg::MONTH_JAN;
          res_o.date.day    = cdad_pkg::DAY_W'(1);
          res_o.date.rem400 = (r == cdad_pkg::REM_W'(cdad_pkg::LEAP_CYCLE - 1)) ?
                              '0 : r + 1'b1;
        end
      end else begin
        res_o.date.month = date_i.month + 1'b1;
        res_o.date.day   = cdad_pkg::DAY_W'(1);
      end
    end else begin
      if (date_i.day > cdad_pkg::DAY_W'(1)) begin
        res_o.date.day = date_i.day - 1'b1;
      end else if (date_i.month == cdad_pkg::MONTH_JAN) begin
        if (date_i.year <= cdad_pkg::YEAR_W'(1)) begin
          res_o.range_err = 1'b1;
        end else begin
          res_o.date.year   = date_i.year - 1'b1;
          res_o.date.month  = cdad_pkg::MONTH_DEC;
          res_o.date.day    = cdad_pkg::DAY_W'(31);
          res_o.date.rem400 = (r == '0) ?
                              cdad_pkg::REM_W'(cdad_pkg::LEAP_CYCLE - 1) : r - 1'b1;
        end
      end else begin
        res_o.date.month = prev_month;
        res_o.date.day   = prev_len;
      end
    end
  end

endmodule
